// ===== src/cnia_pkg.sv =====
// Shared types and constants for the CAN node ID allocation client.
package cnia_pkg;

   // request codes carried in req_type
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_ALLOC = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   // result kinds
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_ASSIGN  = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_UID_LOW          = 3'd0;
   localparam logic [2:0] CSR_UID_HIGH         = 3'd1;
   localparam logic [2:0] CSR_REQUEST_MIN_MS   = 3'd2;
   localparam logic [2:0] CSR_REQUEST_SPAN_MS  = 3'd3;
   localparam logic [2:0] CSR_FOLLOWUP_MIN_MS  = 3'd4;
   localparam logic [2:0] CSR_FOLLOWUP_SPAN_MS = 3'd5;

   // register reset values
   localparam logic [15:0] RESET_REQUEST_MIN_MS   = 16'd600;
   localparam logic [15:0] RESET_REQUEST_SPAN_MS  = 16'd400;
   localparam logic [15:0] RESET_FOLLOWUP_MIN_MS  = 16'd0;
   localparam logic [15:0] RESET_FOLLOWUP_SPAN_MS = 16'd400;

   typedef struct packed {
      logic [63:0] uid_low;
      logic [63:0] uid_high;
      logic [15:0] request_min_ms;
      logic [15:0] request_span_ms;
      logic [15:0] followup_min_ms;
      logic [15:0] followup_span_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] rand_value;
      logic [6:0]  rx_source_id;
      logic [6:0]  rx_node_id;
      logic [4:0]  rx_uid_len;
      logic [63:0] rx_uid_lo;
      logic [63:0] rx_uid_hi;
   } item_type;

   typedef struct packed {
      logic        result_kind;
      logic        first_stage;
      logic [2:0]  chunk_len;
      logic [47:0] uid_chunk;
      logic [6:0]  assigned_node_id;
   } result_type;

   typedef struct packed {
      logic [6:0]  local_node_id;
      logic [16:0] delay_remaining;
      logic [4:0]  uid_offset;
   } state_type;

endpackage

// ===== src/cnia_req_if.sv =====
// Input channel: one allocation client event per transaction.
interface cnia_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] rand_value;
   logic [6:0]  rx_source_id;
   logic [6:0]  rx_node_id;
   logic [4:0]  rx_uid_len;
   logic [63:0] rx_uid_lo;
   logic [63:0] rx_uid_hi;

   modport source (
      output valid, req_type, rand_value, rx_source_id, rx_node_id, rx_uid_len,
             rx_uid_lo, rx_uid_hi,
      input  ready
   );
   modport sink (
      input  valid, req_type, rand_value, rx_source_id, rx_node_id, rx_uid_len,
             rx_uid_lo, rx_uid_hi,
      output ready
   );
endinterface

// ===== src/cnia_rsp_if.sv =====
// Result channel: request frame or node ID assignment per transaction.
interface cnia_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic        first_stage;
   logic [2:0]  chunk_len;
   logic [47:0] uid_chunk;
   logic [6:0]  assigned_node_id;

   modport source (
      output valid, result_kind, first_stage, chunk_len, uid_chunk, assigned_node_id,
      input  ready
   );
   modport sink (
      input  valid, result_kind, first_stage, chunk_len, uid_chunk, assigned_node_id,
      output ready
   );
endinterface

// ===== src/cnia_csr_if.sv =====
// Configuration write channel: register index and write data.
interface cnia_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== src/cnia_csr_regs.sv =====
// Configuration registers of the allocation client.
module cnia_csr_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  logic [2:0]        wr_index,
   input  logic [63:0]       wr_data,
   output cnia_pkg::cfg_type cfg
);
   import cnia_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_index)
            CSR_UID_LOW:          cfg_in.uid_low          = wr_data;
            CSR_UID_HIGH:         cfg_in.uid_high         = wr_data;
            CSR_REQUEST_MIN_MS:   cfg_in.request_min_ms   = wr_data[15:0];
            CSR_REQUEST_SPAN_MS:  cfg_in.request_span_ms  = wr_data[15:0];
            CSR_FOLLOWUP_MIN_MS:  cfg_in.followup_min_ms  = wr_data[15:0];
            CSR_FOLLOWUP_SPAN_MS: cfg_in.followup_span_ms = wr_data[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.uid_low          <= '0;
         cfg_ff.uid_high         <= '0;
         cfg_ff.request_min_ms   <= RESET_REQUEST_MIN_MS;
         cfg_ff.request_span_ms  <= RESET_REQUEST_SPAN_MS;
         cfg_ff.followup_min_ms  <= RESET_FOLLOWUP_MIN_MS;
         cfg_ff.followup_span_ms <= RESET_FOLLOWUP_SPAN_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/cnia_step.sv =====
// Per-item decision logic: next client state and optional result.
module cnia_step #(
   parameter int UID_BYTES   = 16,
   parameter int CHUNK_BYTES = 6
) (
   input  cnia_pkg::cfg_type    cfg,
   input  cnia_pkg::state_type  state,
   input  cnia_pkg::item_type   item,
   output cnia_pkg::state_type  state_next,
   output logic                 emit,
   output cnia_pkg::result_type result
);
   import cnia_pkg::*;

   localparam logic [4:0] UidBytesW   = 5'(UID_BYTES);
   localparam logic [2:0] ChunkBytesW = 3'(CHUNK_BYTES);

   logic [7:0]  own_byte [16];
   logic [7:0]  rx_byte [16];
   logic [31:0] req_prod;
   logic [31:0] fup_prod;
   logic [16:0] req_delay;
   logic [16:0] fup_delay;
   logic [16:0] delay_dec;
   logic [4:0]  len_clamp;
   logic        uid_match;
   logic [4:0]  remain;
   logic [2:0]  clen;
   logic [4:0]  byte_idx;
   logic [47:0] chunk;

   // split UID words into bytes; own bytes past the UID size read as zero
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         own_byte[i]     = cfg.uid_low[8*i +: 8];
         own_byte[i + 8] = cfg.uid_high[8*i +: 8];
         rx_byte[i]      = item.rx_uid_lo[8*i +: 8];
         rx_byte[i + 8]  = item.rx_uid_hi[8*i +: 8];
      end
      for (int i = 0; i < 16; i++) begin
         if (i >= UID_BYTES) begin
            own_byte[i] = 8'd0;
         end
      end
   end

   // delay = min + (rand * span) >> 16
   assign req_prod  = 32'(item.rand_value) * 32'(cfg.request_span_ms);
   assign fup_prod  = 32'(item.rand_value) * 32'(cfg.followup_span_ms);
   assign req_delay = {1'b0, cfg.request_min_ms} + {1'b0, req_prod[31:16]};
   assign fup_delay = {1'b0, cfg.followup_min_ms} + {1'b0, fup_prod[31:16]};

   assign delay_dec = (state.delay_remaining != 17'd0) ?
                      state.delay_remaining - 17'd1 : state.delay_remaining;

   // prefix compare of the received UID against our own
   always_comb begin
      len_clamp = (item.rx_uid_len > UidBytesW) ? UidBytesW : item.rx_uid_len;
      uid_match = 1'b1;
      for (int i = 0; i < 16; i++) begin
         if ((i < UID_BYTES) && (5'(i) < len_clamp) && (own_byte[i] != rx_byte[i])) begin
            uid_match = 1'b0;
         end
      end
   end

   // request chunk starting at the current offset
   always_comb begin
      remain = (state.uid_offset < UidBytesW) ? UidBytesW - state.uid_offset : 5'd0;
      clen   = (remain > 5'(ChunkBytesW)) ? ChunkBytesW : remain[2:0];
      chunk  = '0;
      byte_idx = '0;
      for (int j = 0; j < CHUNK_BYTES; j++) begin
         byte_idx = state.uid_offset + 5'(j);
         if (3'(j) < clen) begin
            chunk[8*j +: 8] = own_byte[byte_idx[3:0]];
         end
      end
   end

   always_comb begin
      state_next = state;
      emit       = 1'b0;
      result     = '0;
      if (state.local_node_id == 7'd0) begin
         case (item.req_type)
            REQ_START: begin
               state_next.delay_remaining = req_delay;
            end
            REQ_TICK: begin
               state_next.delay_remaining = delay_dec;
               if (delay_dec == 17'd0) begin
                  state_next.delay_remaining = req_delay;
                  state_next.uid_offset      = 5'd0;
                  emit                       = 1'b1;
                  result.result_kind         = KIND_REQUEST;
                  result.first_stage         = (state.uid_offset == 5'd0);
                  result.chunk_len           = clen;
                  result.uid_chunk           = chunk;
               end
            end
            REQ_ALLOC: begin
               state_next.delay_remaining = req_delay;
               state_next.uid_offset      = 5'd0;
               if ((item.rx_source_id != 7'd0) && uid_match) begin
                  if (len_clamp < UidBytesW) begin
                     state_next.uid_offset      = len_clamp;
                     state_next.delay_remaining = fup_delay;
                  end else if (item.rx_node_id != 7'd0) begin
                     state_next.local_node_id = item.rx_node_id;
                     emit                     = 1'b1;
                     result.result_kind       = KIND_ASSIGN;
                     result.assigned_node_id  = item.rx_node_id;
                  end
               end
            end
            default: begin
               state_next = state;
            end
         endcase
      end
   end

endmodule

// ===== src/can_node_id_allocation_client_top.sv =====
// Top level of the CAN dynamic node ID allocation client.
//
// Channels: req_ch takes one event per transaction (millisecond tick,
// received allocation message or start), rsp_ch delivers request frames to
// transmit and the one node ID assignment, csr_ch writes the six setup
// registers (own UID words, request and follow-up delay ranges).
// An accepted event is held in an input register; combinational decision
// logic (UID prefix compare, chunk select, the 16x16 multiplies for the random
// delays) updates the client state and loads the result register. A result
// is loaded when its event retires from the input register; events that yield
// no result retire in the cycle after acceptance. One event per cycle is
// accepted while the held event can retire. When the receiver stalls, the
// result register holds; the input register still takes one more event, and
// the input stalls only once an event that yields a result waits behind the
// held one. Synchronous reset clears the node ID, delay counter, UID offset and
// the valid flags of both pipeline registers, and loads the register reset
// values. Once a node ID is assigned all events are consumed without results.
module can_node_id_allocation_client_top #(
   parameter int UID_BYTES   = 16,
   parameter int CHUNK_BYTES = 6
) (
   input logic        clock,
   input logic        reset,
   cnia_req_if.sink   req_ch,
   cnia_rsp_if.source rsp_ch,
   cnia_csr_if.sink   csr_ch
);
   import cnia_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       emit;
   result_type result_in;
   result_type result_ff;
   logic       out_valid_ff;
   logic       out_free;
   logic       advance;
   logic       req_take;

   assign csr_ch.ready = 1'b1;

   cnia_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   cnia_step #(
      .UID_BYTES   (UID_BYTES),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .emit       (emit),
      .result     (result_in)
   );

   // retire the held event unless its result has nowhere to go
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && (out_free || !emit);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.req_type     <= req_ch.req_type;
         item_ff.rand_value   <= req_ch.rand_value;
         item_ff.rx_source_id <= req_ch.rx_source_id;
         item_ff.rx_node_id   <= req_ch.rx_node_id;
         item_ff.rx_uid_len   <= req_ch.rx_uid_len;
         item_ff.rx_uid_lo    <= req_ch.rx_uid_lo;
         item_ff.rx_uid_hi    <= req_ch.rx_uid_hi;
      end
      if (advance && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.result_kind      = result_ff.result_kind;
   assign rsp_ch.first_stage      = result_ff.first_stage;
   assign rsp_ch.chunk_len        = result_ff.chunk_len;
   assign rsp_ch.uid_chunk        = result_ff.uid_chunk;
   assign rsp_ch.assigned_node_id = result_ff.assigned_node_id;

endmodule

// ===== src/cnia_checker.sv =====
// Port-level checks of the allocation client, bound to the top level.
module cnia_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        result_kind,
   input logic        first_stage,
   input logic [2:0]  chunk_len,
   input logic [47:0] uid_chunk,
   input logic [6:0]  assigned_node_id
);
   import cnia_pkg::*;

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input only backs up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a stalled result");

   // request frames always carry UID bytes and no node ID
   a_request_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && result_kind == KIND_REQUEST) |->
         (chunk_len != 3'd0 && assigned_node_id == 7'd0))
      else $error("malformed request frame");

   // an assignment carries a nonzero ID and nothing else
   a_assign_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && result_kind == KIND_ASSIGN) |->
         (assigned_node_id != 7'd0 && !first_stage && chunk_len == 3'd0 &&
          uid_chunk == 48'd0))
      else $error("malformed assignment result");

   // after the assignment is taken the client goes silent
   a_silent_after_assign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && result_kind == KIND_ASSIGN) |=> !rsp_valid)
      else $error("result after node ID assignment");

endmodule

bind can_node_id_allocation_client_top cnia_checker u_cnia_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .result_kind      (rsp_ch.result_kind),
   .first_stage      (rsp_ch.first_stage),
   .chunk_len        (rsp_ch.chunk_len),
   .uid_chunk        (rsp_ch.uid_chunk),
   .assigned_node_id (rsp_ch.assigned_node_id)
);

// ===== bench/can_node_id_allocation_client_top_test.sv =====
// Self-checking bench for the CAN node ID allocation client: directed cases, then random events.
module can_node_id_allocation_client_top_test;
   import cnia_pkg::*;

   localparam int UID_LEN     = 16;
   localparam int CHUNK_LEN   = 6;
   localparam int MAX_REPORTS = 10;
   localparam logic [1:0] REQ_UNUSED = 2'd3;   // reserved request code, dropped by the block

   logic clock;
   logic reset;

   cnia_req_if req_ch();
   cnia_rsp_if rsp_ch();
   cnia_csr_if csr_ch();

   can_node_id_allocation_client_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predicted client: register copy and state
   cfg_type     setup;
   logic [6:0]  node_id;
   logic [16:0] delay_left;
   logic [4:0]  uid_offset_q;
   result_type  results_due[$];

   int fail_count      = 0;
   int sender_idle_pct = 0;
   int recv_idle_pct   = 0;
   int stall_len       = 0;
   int stall_order     = 0;
   int stall_seen      = 0;
   int stall_left      = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

   // receiver: random ready, or a long hold-off when one is ordered
   always @(posedge clock) begin
      if (stall_order != stall_seen) begin
         stall_seen = stall_order;
         stall_left = stall_len;
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void log_failure(input string what, input result_type want,
                                       input result_type seen);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%s: expected kind %0d first %0d len %0d chunk %h id %0d, got kind %0d first %0d len %0d chunk %h id %0d",
                  what, want.result_kind, want.first_stage, want.chunk_len, want.uid_chunk,
                  want.assigned_node_id, seen.result_kind, seen.first_stage, seen.chunk_len,
                  seen.uid_chunk, seen.assigned_node_id);
   endfunction

   always @(posedge clock) begin : check_result
      result_type seen, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = {rsp_ch.result_kind, rsp_ch.first_stage, rsp_ch.chunk_len, rsp_ch.uid_chunk,
                 rsp_ch.assigned_node_id};
         if (results_due.size() == 0) begin
            log_failure("result with none expected", '0, seen);
         end else begin
            want = results_due.pop_front();
            if (seen.result_kind !== want.result_kind || seen.first_stage !== want.first_stage
                || seen.chunk_len !== want.chunk_len || seen.uid_chunk !== want.uid_chunk
                || seen.assigned_node_id !== want.assigned_node_id)
               log_failure("result mismatch", want, seen);
         end
      end
   end

   function automatic logic [16:0] draw_delay(input logic [15:0] floor_ms, input logic [15:0] span_ms,
                                              input logic [15:0] rnd);
      logic [31:0] scaled;
      scaled = 32'(rnd) * 32'(span_ms);
      return 17'(floor_ms) + 17'(scaled[31:16]);
   endfunction

   // update the predicted client with one accepted transaction
   function automatic void advance_client(input item_type ev);
      logic [127:0] own_uid, rx_uid, byte_mask;
      logic [47:0]  chunk;
      logic [2:0]   clen;
      int           avail, span_bytes;
      if (node_id != 7'd0) return;
      own_uid = {setup.uid_high, setup.uid_low};
      case (ev.req_type)
         REQ_START: begin
            delay_left = draw_delay(setup.request_min_ms, setup.request_span_ms, ev.rand_value);
         end
         REQ_TICK: begin
            if (delay_left != 17'd0) delay_left = delay_left - 17'd1;
            if (delay_left == 17'd0) begin
               delay_left = draw_delay(setup.request_min_ms, setup.request_span_ms,
                                       ev.rand_value);
               avail = UID_LEN - int'(uid_offset_q);
               clen  = 3'((avail > CHUNK_LEN) ? CHUNK_LEN : avail);
               chunk = '0;
               for (int i = 0; i < int'(clen); i++)
                  chunk[8*i +: 8] = own_uid[8*(int'(uid_offset_q) + i) +: 8];
               results_due.push_back('{result_kind: KIND_REQUEST,
                                       first_stage: (uid_offset_q == 5'd0),
                                       chunk_len: clen, uid_chunk: chunk,
                                       assigned_node_id: 7'd0});
               uid_offset_q = '0;
            end
         end
         REQ_ALLOC: begin
            delay_left = draw_delay(setup.request_min_ms, setup.request_span_ms, ev.rand_value);
            uid_offset_q = '0;
            if (ev.rx_source_id == 7'd0) return;
            span_bytes = (int'(ev.rx_uid_len) > UID_LEN) ? UID_LEN : int'(ev.rx_uid_len);
            rx_uid = {ev.rx_uid_hi, ev.rx_uid_lo};
            byte_mask = '0;
            for (int i = 0; i < span_bytes; i++) byte_mask[8*i +: 8] = 8'hFF;
            if (((own_uid ^ rx_uid) & byte_mask) != '0) return;
            if (span_bytes < UID_LEN) begin
               uid_offset_q = 5'(span_bytes);
               delay_left = draw_delay(setup.followup_min_ms, setup.followup_span_ms,
                                       ev.rand_value);
               return;
            end
            if (ev.rx_node_id == 7'd0) return;
            node_id = ev.rx_node_id;
            results_due.push_back('{result_kind: KIND_ASSIGN, first_stage: 1'b0,
                                    chunk_len: 3'd0, uid_chunk: 48'd0,
                                    assigned_node_id: ev.rx_node_id});
         end
         default: ;
      endcase
   endfunction

   task automatic send_event(input item_type ev);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= ev.req_type;
      req_ch.rand_value   <= ev.rand_value;
      req_ch.rx_source_id <= ev.rx_source_id;
      req_ch.rx_node_id   <= ev.rx_node_id;
      req_ch.rx_uid_len   <= ev.rx_uid_len;
      req_ch.rx_uid_lo    <= ev.rx_uid_lo;
      req_ch.rx_uid_hi    <= ev.rx_uid_hi;
      do @(posedge clock); while (!req_ch.ready);
      advance_client(ev);
   endtask

   // drop valid, wait for every expected result, then let the pipeline empty
   task automatic settle();
      int waited;
      req_ch.valid <= 1'b0;
      waited = 0;
      while (results_due.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
   endtask

   task automatic load_setup(input cfg_type cfg);
      logic [47:0] noise;
      for (int r = int'(CSR_UID_LOW); r <= int'(CSR_FOLLOWUP_SPAN_MS); r++) begin
         noise = 48'({$urandom, $urandom});
         csr_ch.valid <= 1'b1;
         csr_ch.index <= 3'(r);
         // upper bits of the 16-bit registers carry junk that must be dropped
         case (3'(r))
            CSR_UID_LOW:          csr_ch.data <= cfg.uid_low;
            CSR_UID_HIGH:         csr_ch.data <= cfg.uid_high;
            CSR_REQUEST_MIN_MS:   csr_ch.data <= {noise, cfg.request_min_ms};
            CSR_REQUEST_SPAN_MS:  csr_ch.data <= {noise, cfg.request_span_ms};
            CSR_FOLLOWUP_MIN_MS:  csr_ch.data <= {noise, cfg.followup_min_ms};
            CSR_FOLLOWUP_SPAN_MS: csr_ch.data <= {noise, cfg.followup_span_ms};
            default:              csr_ch.data <= '0;
         endcase
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
      setup = cfg;
      @(posedge clock);
   endtask

   function automatic cfg_type random_setup();
      cfg_type cfg;
      cfg.uid_low  = {$urandom, $urandom};
      cfg.uid_high = {$urandom, $urandom};
      case ($urandom_range(3))
         0: cfg.uid_low = '1;
         1: cfg.uid_high = '0;
         default: ;
      endcase
      cfg.request_min_ms   = 16'($urandom_range(2));
      cfg.request_span_ms  = 16'($urandom_range(5));
      cfg.followup_min_ms  = 16'($urandom_range(1));
      cfg.followup_span_ms = 16'($urandom_range(4));
      return cfg;
   endfunction

   function automatic item_type noisy_event(input logic [1:0] kind);
      item_type ev;
      ev.req_type     = kind;
      ev.rand_value   = 16'($urandom);
      ev.rx_source_id = 7'($urandom);
      ev.rx_node_id   = 7'($urandom);
      ev.rx_uid_len   = 5'($urandom);
      ev.rx_uid_lo    = {$urandom, $urandom};
      ev.rx_uid_hi    = {$urandom, $urandom};
      return ev;
   endfunction

   // allocation message that echoes the first len bytes of the own UID
   function automatic item_type echo_event(input int len, input logic [6:0] src,
                                           input logic [6:0] nid);
      item_type     ev;
      logic [127:0] own_uid, keep;
      ev = noisy_event(REQ_ALLOC);
      own_uid = {setup.uid_high, setup.uid_low};
      keep = '0;
      for (int i = 0; i < len && i < UID_LEN; i++) keep[8*i +: 8] = 8'hFF;
      {ev.rx_uid_hi, ev.rx_uid_lo} = (own_uid & keep) | ({ev.rx_uid_hi, ev.rx_uid_lo} & ~keep);
      ev.rx_source_id = src;
      ev.rx_node_id   = nid;
      ev.rx_uid_len   = 5'(len);
      return ev;
   endfunction

   function automatic item_type spoil_byte(input item_type ev, input int b);
      logic [127:0] rx_uid;
      rx_uid = {ev.rx_uid_hi, ev.rx_uid_lo};
      rx_uid[8*b +: 8] = rx_uid[8*b +: 8] ^ 8'($urandom_range(255, 1));
      {ev.rx_uid_hi, ev.rx_uid_lo} = rx_uid;
      return ev;
   endfunction

   task automatic test_reset_values();
      // delay counter is clear after reset, so the first tick sends at once
      send_event(noisy_event(REQ_TICK));
      send_event(noisy_event(REQ_TICK));
      settle();
   endtask

   task automatic test_delay_extremes();
      cfg_type  cfg;
      item_type ev;
      cfg = '{uid_low: '1, uid_high: {$urandom, $urandom},
              request_min_ms: 16'hFFFF, request_span_ms: 16'hFFFF,
              followup_min_ms: 16'hFFFF, followup_span_ms: 16'hFFFF};
      load_setup(cfg);
      ev = noisy_event(REQ_START);
      ev.rand_value = 16'hFFFF;
      send_event(ev);
      send_event(noisy_event(REQ_TICK));
      ev = echo_event(3, 7'd5, 7'($urandom));
      ev.rand_value = 16'hFFFF;
      send_event(ev);
      send_event(noisy_event(REQ_TICK));
      settle();
      cfg = '{uid_low: '0, uid_high: '1, request_min_ms: '0, request_span_ms: '0,
              followup_min_ms: '0, followup_span_ms: '0};
      load_setup(cfg);
      ev = noisy_event(REQ_START);
      ev.rand_value = 16'hFFFF;
      send_event(ev);
      // zero delay: every tick sends, the first one from the kept offset
      send_event(noisy_event(REQ_TICK));
      send_event(noisy_event(REQ_TICK));
      settle();
   endtask

   task automatic test_allocation_paths();
      cfg_type cfg;
      cfg = random_setup();
      cfg.request_min_ms   = 16'd2;
      cfg.request_span_ms  = '0;
      cfg.followup_min_ms  = 16'd1;
      cfg.followup_span_ms = '0;
      load_setup(cfg);
      send_event(echo_event(UID_LEN, 7'd0, 7'd55));   // anonymous allocator only re-arms
      send_event(echo_event(CHUNK_LEN, 7'd127, 7'($urandom)));
      send_event(noisy_event(REQ_TICK));
      send_event(echo_event(2 * CHUNK_LEN, 7'd1, 7'($urandom)));
      send_event(noisy_event(REQ_TICK));
      send_event(echo_event(UID_LEN - 1, 7'd64, 7'($urandom)));
      send_event(noisy_event(REQ_TICK));
      send_event(echo_event(0, 7'd3, 7'($urandom)));   // empty UID still matches
      send_event(noisy_event(REQ_TICK));
      send_event(spoil_byte(echo_event(9, 7'd9, 7'($urandom)), 8));
      send_event(noisy_event(REQ_TICK));
      send_event(noisy_event(REQ_TICK));
      send_event(echo_event(31, 7'd100, 7'd0));   // oversized length, full match, zero ID
      send_event(noisy_event(REQ_UNUSED));
      send_event(echo_event(CHUNK_LEN, 7'd42, 7'($urandom)));
      send_event(noisy_event(REQ_START));   // re-arm but hold the offset
      send_event(noisy_event(REQ_TICK));
      send_event(noisy_event(REQ_TICK));
      settle();
   endtask

   task automatic run_random_traffic(input int count);
      item_type ev;
      int       pick, len;
      load_setup(random_setup());
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            ev = noisy_event(REQ_TICK);
         end else if (pick < 78) begin
            len = ($urandom_range(1) != 0) ? CHUNK_LEN * $urandom_range(2, 1)
                                           : $urandom_range(UID_LEN - 1);
            ev = echo_event(len, 7'($urandom_range(127, 1)), 7'($urandom));
         end else if (pick < 81) begin
            ev = echo_event($urandom_range(31, UID_LEN), 7'($urandom_range(127, 1)), 7'd0);
         end else if (pick < 88) begin
            len = $urandom_range(31, 1);
            ev = spoil_byte(echo_event(len, 7'($urandom_range(127, 1)), 7'($urandom)),
                            $urandom_range(((len > UID_LEN) ? UID_LEN : len) - 1));
         end else if (pick < 92) begin
            ev = echo_event($urandom_range(31), 7'd0, 7'($urandom));
         end else if (pick < 97) begin
            ev = noisy_event(REQ_START);
         end else begin
            ev = noisy_event(REQ_UNUSED);
         end
         send_event(ev);
      end
      settle();
   endtask

   task automatic test_result_backpressure();
      cfg_type cfg;
      cfg = random_setup();
      cfg.request_min_ms  = '0;
      cfg.request_span_ms = '0;
      load_setup(cfg);
      stall_len = 300;
      stall_order++;
      repeat (40) send_event(noisy_event(REQ_TICK));
      settle();
   endtask

   task automatic test_node_assignment();
      cfg_type cfg;
      cfg = random_setup();
      cfg.request_min_ms  = '0;
      cfg.request_span_ms = '0;
      load_setup(cfg);
      send_event(noisy_event(REQ_TICK));
      send_event(echo_event($urandom_range(31, UID_LEN), 7'($urandom_range(127, 1)),
                            7'($urandom_range(127, 1))));
      // named now: drop everything that follows
      send_event(noisy_event(REQ_TICK));
      send_event(noisy_event(REQ_START));
      send_event(echo_event(CHUNK_LEN, 7'd7, 7'($urandom)));
      send_event(noisy_event(REQ_TICK));
      settle();
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_TICK;
      req_ch.rand_value   = '0;
      req_ch.rx_source_id = '0;
      req_ch.rx_node_id   = '0;
      req_ch.rx_uid_len   = '0;
      req_ch.rx_uid_lo    = '0;
      req_ch.rx_uid_hi    = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_UID_LOW;
      csr_ch.data         = '0;
      setup = '{uid_low: '0, uid_high: '0,
                request_min_ms: RESET_REQUEST_MIN_MS, request_span_ms: RESET_REQUEST_SPAN_MS,
                followup_min_ms: RESET_FOLLOWUP_MIN_MS,
                followup_span_ms: RESET_FOLLOWUP_SPAN_MS};
      node_id      = '0;
      delay_left   = '0;
      uid_offset_q = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 7;
      recv_idle_pct   = 86;
      test_reset_values();
      test_delay_extremes();
      test_allocation_paths();
      run_random_traffic(520);

      sender_idle_pct = 86;
      recv_idle_pct   = 7;
      run_random_traffic(520);

      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      run_random_traffic(520);
      test_result_backpressure();
      test_node_assignment();

      if (results_due.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
